// ===== src/esmi_pkg.sv =====
// Package for the electrode switch / mode relay interlock.
// Holds command, mode, probe and status codes, masks and the state struct.
// No dependencies.
package esmi_pkg;

  // Command codes
  localparam logic [1:0] FUNC_SELECT = 2'd0;
  localparam logic [1:0] FUNC_MODE   = 2'd1;
  localparam logic [1:0] FUNC_MAP    = 2'd2;

  // Work modes
  localparam logic [2:0] MODE_MAPPING = 3'd0;
  localparam logic [2:0] MODE_CONTACT = 3'd1;
  localparam logic [2:0] MODE_LOOP    = 3'd2;
  localparam logic [2:0] MODE_ABL     = 3'd3;
  localparam logic [2:0] MODE_UNSET   = 3'd4;

  // Probe kinds
  localparam logic [1:0] KIND_PVI1    = 2'd0;
  localparam logic [1:0] KIND_PVI2    = 2'd1;
  localparam logic [1:0] KIND_FOCAL   = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // Polarity schemes
  localparam logic [1:0] POL_A = 2'd0;
  localparam logic [1:0] POL_B = 2'd1;
  localparam logic [1:0] POL_C = 2'd2;
  localparam logic [1:0] POL_D = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NO_MODE = 2'd2;

  // Bitmap masks
  localparam int unsigned MAP_W = 25;
  localparam int unsigned POLE_W = 24;
  localparam logic [MAP_W-1:0] FOCAL_MASK = 25'h1999998;
  localparam logic [MAP_W-1:0] PVI1_MASK  = 25'h1111110;
  localparam logic [MAP_W-1:0] TOP_BIT    = 25'h0000001;

  // Relay and polarity pin levels (active low relays)
  typedef struct packed {
    logic pole_pol;
    logic top_pol;
    logic neg_plate;
    logic loop_rly;
    logic contact;
    logic ecg;
  } esmi_pins_t;

  // Architectural state; top wire and expander follow from applied map
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       pol;
    logic [2:0]       mode;
    logic [MAP_W-1:0] preset;
    logic [MAP_W-1:0] applied;
    esmi_pins_t       pins;
  } esmi_state_t;

  localparam esmi_state_t STATE_RESET = '{
    kind:    KIND_NONE,
    pol:     POL_A,
    mode:    MODE_UNSET,
    preset:  '0,
    applied: '0,
    pins:    '1
  };

endpackage

// ===== src/esmi_core.sv =====
// Next-state and status logic for one command of the interlock.
// Purely combinational; depends on esmi_pkg.
module esmi_core (
  input  esmi_pkg::esmi_state_t  cur_i,
  input  logic [1:0]             func_i,
  input  logic [1:0]             probe_type_i,
  input  logic [1:0]             probe_polarity_i,
  input  logic [2:0]             new_mode_i,
  input  logic [esmi_pkg::MAP_W-1:0] elec_bitmap_i,
  output esmi_pkg::esmi_state_t  nxt_o,
  output logic [1:0]             status_o
);

  typedef struct packed {
    logic                  ok;
    esmi_pkg::esmi_state_t st;
  } run_t;

  // Applied bitmap: preset in loop/ablation, cleared in mapping/contact
  function automatic esmi_pkg::esmi_state_t apply_map(esmi_pkg::esmi_state_t s);
    esmi_pkg::esmi_state_t r;
    r = s;
    case (s.mode) inside
      esmi_pkg::MODE_LOOP, esmi_pkg::MODE_ABL:        r.applied = s.preset;
      esmi_pkg::MODE_MAPPING, esmi_pkg::MODE_CONTACT: r.applied = '0;
      default:                                        r.applied = s.applied;
    endcase
    return r;
  endfunction

  // Enter a mode with the stored probe pair
  function automatic run_t run_mode(esmi_pkg::esmi_state_t s, logic [2:0] m);
    run_t r;
    logic pol_ok;
    r.ok = 1'b0;
    r.st = s;
    pol_ok = 1'b0;
    case (m)
      esmi_pkg::MODE_MAPPING, esmi_pkg::MODE_CONTACT: begin
        if (!(m == esmi_pkg::MODE_CONTACT && s.kind == esmi_pkg::KIND_PVI1)) begin
          r.st.pins.ecg       = (m == esmi_pkg::MODE_CONTACT);
          r.st.pins.contact   = (m == esmi_pkg::MODE_MAPPING);
          r.st.pins.loop_rly  = 1'b1;
          r.st.pins.neg_plate = 1'b1;
          r.st.pins.top_pol   = 1'b1;
          r.st.pins.pole_pol  = 1'b1;
          r.st.mode = m;
          r.st      = apply_map(r.st);
          r.ok      = 1'b1;
        end
      end
      esmi_pkg::MODE_LOOP, esmi_pkg::MODE_ABL: begin
        // relays switch even if the polarity check fails
        r.st.pins.ecg      = 1'b1;
        r.st.pins.contact  = 1'b1;
        r.st.pins.loop_rly = (m == esmi_pkg::MODE_ABL);
        case (s.pol)
          esmi_pkg::POL_A: pol_ok = 1'b1;
          esmi_pkg::POL_B, esmi_pkg::POL_C:
            pol_ok = (s.kind == esmi_pkg::KIND_PVI2) || (s.kind == esmi_pkg::KIND_FOCAL);
          default: pol_ok = (s.kind == esmi_pkg::KIND_PVI2);
        endcase
        if (pol_ok) begin
          r.st.pins.neg_plate = (s.pol != esmi_pkg::POL_B);
          r.st.pins.top_pol   = (s.pol == esmi_pkg::POL_A) || (s.pol == esmi_pkg::POL_B);
          r.st.pins.pole_pol  = (s.pol == esmi_pkg::POL_B) || (s.pol == esmi_pkg::POL_C);
          r.st.mode = m;
          r.st      = apply_map(r.st);
          r.ok      = 1'b1;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  run_t                  rerun;
  run_t                  setm;
  esmi_pkg::esmi_state_t sel_st;
  esmi_pkg::esmi_state_t map_st;
  logic                  pair_ok;
  logic                  map_ok;

  // Probe pair check
  always_comb begin
    case (probe_type_i)
      esmi_pkg::KIND_PVI1:  pair_ok = (probe_polarity_i == esmi_pkg::POL_A);
      esmi_pkg::KIND_PVI2:  pair_ok = 1'b1;
      esmi_pkg::KIND_FOCAL: pair_ok = (probe_polarity_i != esmi_pkg::POL_D);
      default:              pair_ok = 1'b0;
    endcase
  end

  // Bitmap rules against the stored probe
  always_comb begin
    map_ok = 1'b1;
    if (cur_i.kind == esmi_pkg::KIND_FOCAL && |(elec_bitmap_i & esmi_pkg::FOCAL_MASK))
      map_ok = 1'b0;
    if (cur_i.kind == esmi_pkg::KIND_PVI1 && |(elec_bitmap_i & esmi_pkg::PVI1_MASK))
      map_ok = 1'b0;
    if (cur_i.pol == esmi_pkg::POL_A && elec_bitmap_i[0])
      map_ok = 1'b0;
    if ((cur_i.pol == esmi_pkg::POL_C || cur_i.pol == esmi_pkg::POL_D) && !elec_bitmap_i[0])
      map_ok = 1'b0;
  end

  // Candidate results of each command
  always_comb begin
    sel_st      = cur_i;
    sel_st.kind = probe_type_i;
    sel_st.pol  = probe_polarity_i;
    rerun       = run_mode(sel_st, cur_i.mode);
    setm        = run_mode(cur_i, new_mode_i);
    map_st        = cur_i;
    map_st.preset = elec_bitmap_i;
    if (cur_i.mode == esmi_pkg::MODE_LOOP || cur_i.mode == esmi_pkg::MODE_ABL)
      map_st = apply_map(map_st);
  end

  // Command select
  always_comb begin
    nxt_o    = cur_i;
    status_o = esmi_pkg::STATUS_INVALID;
    case (func_i)
      esmi_pkg::FUNC_SELECT: begin
        if (pair_ok) begin
          // status is OK whatever the outcome of the re-run
          nxt_o    = rerun.ok ? rerun.st : sel_st;
          if (!rerun.ok) nxt_o.pins = rerun.st.pins;
          status_o = esmi_pkg::STATUS_OK;
        end
      end
      esmi_pkg::FUNC_MODE: begin
        nxt_o    = setm.st;
        status_o = setm.ok ? esmi_pkg::STATUS_OK : esmi_pkg::STATUS_INVALID;
      end
      esmi_pkg::FUNC_MAP: begin
        if (map_ok) begin
          nxt_o    = map_st;
          status_o = esmi_pkg::STATUS_OK;
        end
      end
      default: begin
        nxt_o    = cur_i;
        status_o = esmi_pkg::STATUS_INVALID;
      end
    endcase
  end

endmodule

// ===== src/electrode_switch_mode_interlock_unit.sv =====
// Top level of the electrode switch / mode relay interlock.
// Depends on esmi_pkg and esmi_core.
//
//  channel | dir | tuser     | tdata, low bit up
//  s_axis  | in  | func[1:0] | probe_type[1:0] probe_polarity[3:2] new_mode[6:4] elec_bitmap[31:7]
//  m_axis  | out | -         | status[1:0] mode_now[4:2] pins[11:5] expander_out[35:12], pad 40
//  (pins low bit up: ecg contact loop neg_plate top_pol pole_pol top_wire)
//
// One command per cycle while results are taken; its result word is registered on acceptance.
// State and result update in the same edge through esmi_core, one register stage.
// Reset puts the probe to none, mode to unset, all pins high and no result pending.
// A stalled result word blocks input only while it is not taken.
module electrode_switch_mode_interlock_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // func
  input  logic [31:0] s_axis_tdata,  // probe_type, probe_polarity, new_mode, elec_bitmap
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status, mode_now, 7 pins, expander_out
);

  esmi_pkg::esmi_state_t state_q, state_d;
  logic [1:0]            status_d;
  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic                  accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Command evaluation
  esmi_core u_core (
    .cur_i            (state_q),
    .func_i           (s_axis_tuser),
    .probe_type_i     (s_axis_tdata[1:0]),
    .probe_polarity_i (s_axis_tdata[3:2]),
    .new_mode_i       (s_axis_tdata[6:4]),
    .elec_bitmap_i    (s_axis_tdata[31:7]),
    .nxt_o            (state_d),
    .status_o         (status_d)
  );

  // State and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= esmi_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Status of the last accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= esmi_pkg::STATUS_OK;
    end else if (accept) begin
      status_q <= status_d;
    end
  end

  // Result word; switch outputs follow the applied bitmap
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0,
                          ~state_q.applied[esmi_pkg::MAP_W-1:1],
                          ~state_q.applied[0],
                          state_q.pins.pole_pol,
                          state_q.pins.top_pol,
                          state_q.pins.neg_plate,
                          state_q.pins.loop_rly,
                          state_q.pins.contact,
                          state_q.pins.ecg,
                          state_q.mode,
                          status_q};

endmodule

// ===== src/esmi_checker.sv =====
// Port-level checks for the interlock top level, with its bind.
// Depends on electrode_switch_mode_interlock_unit.
module esmi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A held result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // No input taken while the result slot is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input accepted over a stalled result");

  // Mode not initialised is never reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != esmi_pkg::STATUS_NO_MODE)
    else $error("unexpected status code");

  // Mapping, contact or unset: electrodes open, polarity pins high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[4:2] == esmi_pkg::MODE_MAPPING ||
                      m_axis_tdata[4:2] == esmi_pkg::MODE_CONTACT ||
                      m_axis_tdata[4:2] == esmi_pkg::MODE_UNSET)
    |-> m_axis_tdata[35:8] == '1)
    else $error("electrodes closed outside loop or ablation");

endmodule

bind electrode_switch_mode_interlock_unit esmi_checker u_esmi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
